>>> hw/rtl/scs_pkg.sv
package scs_pkg;

    localparam int KEY_W      = 64;
    localparam int LEN_W      = 4;
    localparam int INC_W      = 32;
    localparam int ACT_W      = 2;
    localparam int EST_W      = 56;
    localparam int S_DATA_W   = 104;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ROWS_W     = 4;
    localparam int COLS_W     = 11;
    localparam int PROB_W     = 17;
    localparam int GAIN_W     = 25;
    localparam int SEED_W     = 32;
    localparam int ROWPTR_W   = 9;

    localparam logic [63:0]       FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [31:0]       LFSR_TAPS = 32'h80200003;
    localparam logic [EST_W-1:0]  CNT_MAX   = {EST_W{1'b1}};
    localparam logic [PROB_W-1:0] PROB_MAX  = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_MAX  = 25'd16777216;
    localparam logic [LEN_W-1:0]  KEY_BYTES = 4'd8;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD, ACT_MEAN, ACT_MEDIAN, ACT_CLEAR
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS, CFG_COLS, CFG_PROB, CFG_GAIN, CFG_SEED
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_DISP, ST_MUL, ST_ROW, ST_HASH, ST_MOD, ST_RD,
        ST_SKIP, ST_MEAN, ST_MEANW, ST_SORT, ST_SHIFT, ST_CLR, ST_FIN
    } state_t;

    typedef struct packed {
        logic load_in;
        logic sweep_step;
        logic seed_load;
        logic mul;
        logic iter_init;
        logic row_wrap;
        logic hash_init;
        logic hash_step;
        logic div_mod;
        logic div_mean;
        logic mem_rd;
        logic acc;
        logic skip_step;
        logic sort_step;
        logic shift_step;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    row_ge;
        logic    iter_done;
        logic    hash_done;
        logic    div_done;
        logic    skip_end;
        logic    sort_done;
        logic    shift_done;
        logic    sweep_last;
        logic    out_full;
    } status_t;

    // one fnv-1a byte: xor then multiply by 2^40 + 0x1b3
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

    // offset basis raised by 31 per row
    function automatic logic [63:0] row_basis(input logic [7:0] r);
        return FNV_BASIS + ({56'd0, r} << 5) - {56'd0, r};
    endfunction

endpackage

>>> hw/rtl/scs_div.sv
module scs_div #(
    parameter int DW = 64,
    parameter int VW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [VW-1:0] rem
);
    localparam int CNTW = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   quot_reg, quot_next;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [VW-1:0]   div_reg, div_next;
    logic [VW:0]     trial;
    logic            ge;

    // restoring division, one quotient bit a cycle
    always_comb begin
        trial     = {rem_reg, quot_reg[DW-1]};
        ge        = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(DW);
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[DW-2:0], ge};
            rem_next  = ge ? VW'(trial - {1'b0, div_reg}) : trial[VW-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

>>> hw/rtl/scs_dp.sv
module scs_dp #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_SKIP    = 255
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  scs_pkg::cmd_t                    cmd,
    output scs_pkg::status_t                 st,
    input  logic [scs_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [scs_pkg::ACT_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [scs_pkg::EST_W-1:0]        m_tdata,
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int KW    = $clog2(MAX_SKIP + 1);
    localparam int L1    = (MAX_ROWS > 1) ? 1 : 0;
    localparam int EW    = scs_pkg::EST_W;

    // configuration
    logic [scs_pkg::ROWS_W-1:0] rows_cfg_reg;
    logic [scs_pkg::COLS_W-1:0] cols_cfg_reg;
    logic [scs_pkg::PROB_W-1:0] prob_cfg_reg;
    logic [scs_pkg::GAIN_W-1:0] gain_cfg_reg;
    logic [scs_pkg::SEED_W-1:0] seed_cfg_reg;

    logic [RCW-1:0]                rows_eff;
    logic [scs_pkg::COLS_W-1:0]    cols_eff;
    logic [scs_pkg::PROB_W-1:0]    prob_eff;
    logic [scs_pkg::GAIN_W-1:0]    gain_eff;

    scs_pkg::action_t              act_reg;
    logic [scs_pkg::KEY_W-1:0]     key_reg;
    logic [scs_pkg::LEN_W-1:0]     len_reg;
    logic [scs_pkg::INC_W-1:0]     inc_reg;

    logic [scs_pkg::ROWPTR_W-1:0]  next_row_reg;
    logic [31:0]                   lfsr_reg;
    logic [31:0]                   lfsr_nxt;
    logic [RIW-1:0]                row_reg;
    logic [RIW-1:0]                row_sel;
    logic [RCW-1:0]                iter_reg;
    logic [63:0]                   h_reg;
    logic [scs_pkg::LEN_W-1:0]     bcnt_reg;
    logic [scs_pkg::LEN_W-1:0]     n_bytes;
    logic [EW-1:0]                 amt_reg;
    logic                          sat_reg;
    logic [63:0]                   total_reg;
    logic [EW-1:0]                 lane_reg [MAX_ROWS];
    logic [EW-1:0]                 lane_sorted [MAX_ROWS];
    logic [EW-1:0]                 lane_shift [MAX_ROWS];
    logic [RCW-1:0]                pass_reg;
    logic [RCW-1:0]                shcnt_reg;
    logic [KW-1:0]                 k_reg;
    logic [AW-1:0]                 addr_reg;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 sweep_reg;
    logic [EW-1:0]                 rd_reg;
    logic [EW-1:0]                 mem [DEPTH];
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [EW-1:0]                 wr_data;
    logic [EW:0]                   sum;
    logic [EW-1:0]                 sum_sat;
    logic [EW+1:0]                 prod;
    logic                          skip_end;
    logic                          out_valid_reg;
    logic [EW-1:0]                 out_est_reg;
    logic                          out_sat_reg;
    logic [EW-1:0]                 est;
    logic [EW:0]                   mid_sum;

    logic                          div_start;
    logic [63:0]                   div_dividend;
    logic [scs_pkg::COLS_W-1:0]    div_divisor;
    logic                          div_done;
    logic [63:0]                   div_quot;
    logic [scs_pkg::COLS_W-1:0]    div_rem;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= 4'd8;
            cols_cfg_reg <= 11'd1024;
            prob_cfg_reg <= 17'd65536;
            gain_cfg_reg <= 25'd256;
            seed_cfg_reg <= 32'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                scs_pkg::CFG_ROWS: rows_cfg_reg <= cfg_data[scs_pkg::ROWS_W-1:0];
                scs_pkg::CFG_COLS: cols_cfg_reg <= cfg_data[scs_pkg::COLS_W-1:0];
                scs_pkg::CFG_PROB: prob_cfg_reg <= cfg_data[scs_pkg::PROB_W-1:0];
                scs_pkg::CFG_GAIN: gain_cfg_reg <= cfg_data[scs_pkg::GAIN_W-1:0];
                scs_pkg::CFG_SEED: seed_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp registers into their working ranges
    always_comb begin
        if (rows_cfg_reg == '0)                 rows_eff = RCW'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS)  rows_eff = RCW'(MAX_ROWS);
        else                                    rows_eff = RCW'(rows_cfg_reg);
        if (cols_cfg_reg == '0)                    cols_eff = 11'd1;
        else if (32'(cols_cfg_reg) > MAX_COLUMNS)  cols_eff = scs_pkg::COLS_W'(MAX_COLUMNS);
        else                                       cols_eff = cols_cfg_reg;
        if (prob_cfg_reg == '0)                     prob_eff = 17'd1;
        else if (prob_cfg_reg > scs_pkg::PROB_MAX)  prob_eff = scs_pkg::PROB_MAX;
        else                                        prob_eff = prob_cfg_reg;
        if (gain_cfg_reg == '0)                     gain_eff = 25'd1;
        else if (gain_cfg_reg > scs_pkg::GAIN_MAX)  gain_eff = scs_pkg::GAIN_MAX;
        else                                        gain_eff = gain_cfg_reg;
    end

    assign n_bytes  = (len_reg > scs_pkg::KEY_BYTES) ? scs_pkg::KEY_BYTES : len_reg;
    assign row_sel  = (act_reg == scs_pkg::ACT_ADD) ? RIW'(next_row_reg) : RIW'(iter_reg);
    assign lfsr_nxt = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? scs_pkg::LFSR_TAPS : 32'd0);
    assign skip_end = ({1'b0, lfsr_nxt[15:0]} < prob_eff) || (32'(k_reg) >= MAX_SKIP);
    assign prod     = (EW+2)'(inc_reg) * (EW+2)'(gain_eff);
    assign sum      = {1'b0, rd_reg} + {1'b0, amt_reg};
    assign sum_sat  = sum[EW] ? scs_pkg::CNT_MAX : sum[EW-1:0];
    assign rd_addr  = AW'(32'(row_reg) * MAX_COLUMNS + 32'(div_rem));

    assign div_start    = cmd.div_mod | cmd.div_mean;
    assign div_dividend = cmd.div_mod ? h_reg : total_reg;
    assign div_divisor  = cmd.div_mod ? cols_eff : scs_pkg::COLS_W'(rows_eff);

    scs_div #(.DW(64), .VW(scs_pkg::COLS_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // counter store
    assign wr_en   = cmd.sweep_step | (cmd.acc & (act_reg == scs_pkg::ACT_ADD));
    assign wr_addr = cmd.sweep_step ? sweep_reg : addr_reg;
    assign wr_data = cmd.sweep_step ? '0 : sum_sat;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (cmd.mem_rd) rd_reg <= mem[rd_addr];
    end

    // odd-even transposition pass and shift-down for the median pick
    always_comb begin
        for (int j = 0; j < MAX_ROWS; j++) begin
            lane_sorted[j] = lane_reg[j];
            lane_shift[j]  = (j < MAX_ROWS - 1) ? lane_reg[(j < MAX_ROWS - 1) ? j + 1 : j]
                                                : scs_pkg::CNT_MAX;
        end
        for (int j = 0; j < MAX_ROWS - 1; j++) begin
            if ((j % 2) == int'(pass_reg[0]) && lane_reg[j] > lane_reg[j+1]) begin
                lane_sorted[j]   = lane_reg[j+1];
                lane_sorted[j+1] = lane_reg[j];
            end
        end
    end

    always_comb begin
        mid_sum = {1'b0, lane_reg[0]} + {1'b0, lane_reg[L1]};
        case (act_reg)
            scs_pkg::ACT_MEAN:   est = div_quot[EW-1:0];
            scs_pkg::ACT_MEDIAN: est = rows_eff[0] ? lane_reg[0] : mid_sum[EW:1];
            default:             est = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_row_reg  <= '0;
            lfsr_reg      <= 32'd1;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.sweep_step)
                sweep_reg <= (sweep_reg == AW'(DEPTH - 1)) ? '0 : sweep_reg + 1'b1;
            if (cmd.seed_load)
                lfsr_reg <= (seed_cfg_reg == '0) ? 32'd1 : seed_cfg_reg;
            else if (cmd.skip_step)
                lfsr_reg <= lfsr_nxt;
            if (cmd.row_wrap)
                next_row_reg <= next_row_reg - scs_pkg::ROWPTR_W'(rows_eff);
            else if (cmd.skip_step && skip_end)
                next_row_reg <= scs_pkg::ROWPTR_W'(32'(row_reg) + 32'(k_reg));
            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg <= scs_pkg::action_t'(s_tuser);
            key_reg <= s_tdata[63:0];
            len_reg <= s_tdata[67:64];
            inc_reg <= s_tdata[99:68];
            sat_reg <= 1'b0;
        end
        if (cmd.mul) begin
            amt_reg <= (prod > (EW+2)'(scs_pkg::CNT_MAX)) ? scs_pkg::CNT_MAX : prod[EW-1:0];
            if (prod > (EW+2)'(scs_pkg::CNT_MAX)) sat_reg <= 1'b1;
        end
        if (cmd.iter_init) begin
            iter_reg  <= '0;
            total_reg <= '0;
            pass_reg  <= '0;
            shcnt_reg <= '0;
            for (int j = 0; j < MAX_ROWS; j++) lane_reg[j] <= scs_pkg::CNT_MAX;
        end
        if (cmd.hash_init) begin
            row_reg  <= row_sel;
            h_reg    <= scs_pkg::row_basis(8'(row_sel));
            bcnt_reg <= '0;
        end
        if (cmd.hash_step) begin
            h_reg    <= scs_pkg::fnv_step(h_reg, key_reg[{bcnt_reg[2:0], 3'b000} +: 8]);
            bcnt_reg <= bcnt_reg + 1'b1;
        end
        if (cmd.mem_rd) addr_reg <= rd_addr;
        if (cmd.acc) begin
            if (act_reg == scs_pkg::ACT_ADD) begin
                if (sum[EW]) sat_reg <= 1'b1;
                if (32'(row_reg) == 32'(rows_eff) - 1) row_reg <= '0;
                k_reg <= KW'(1);
            end else begin
                total_reg <= total_reg + 64'(rd_reg);
                lane_reg[iter_reg[RIW-1:0]] <= rd_reg;
                iter_reg  <= iter_reg + 1'b1;
            end
        end
        if (cmd.skip_step) begin
            if (skip_end) iter_reg <= iter_reg + 1'b1;
            else          k_reg    <= k_reg + 1'b1;
        end
        if (cmd.sort_step) begin
            for (int j = 0; j < MAX_ROWS; j++) lane_reg[j] <= lane_sorted[j];
            pass_reg <= pass_reg + 1'b1;
        end
        if (cmd.shift_step) begin
            for (int j = 0; j < MAX_ROWS; j++) lane_reg[j] <= lane_shift[j];
            shcnt_reg <= shcnt_reg + 1'b1;
        end
        if (cmd.res_load) begin
            out_est_reg <= est;
            out_sat_reg <= sat_reg;
        end
    end

    always_comb begin
        st.act        = act_reg;
        st.row_ge     = 32'(next_row_reg) >= 32'(rows_eff);
        st.iter_done  = iter_reg == rows_eff;
        st.hash_done  = bcnt_reg == n_bytes;
        st.div_done   = div_done;
        st.skip_end   = skip_end;
        st.sort_done  = pass_reg == RCW'(MAX_ROWS);
        st.shift_done = shcnt_reg == ((rows_eff - 1'b1) >> 1);
        st.sweep_last = sweep_reg == AW'(DEPTH - 1);
        st.out_full   = out_valid_reg & ~m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_est_reg;
    assign m_tuser  = out_sat_reg;

endmodule

>>> hw/rtl/scs_ctrl.sv
module scs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  scs_pkg::status_t st,
    output scs_pkg::cmd_t    cmd,
    output logic             in_ready
);
    scs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scs_pkg::ST_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            scs_pkg::ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (st.sweep_last) state_next = scs_pkg::ST_IDLE;
            end
            scs_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = scs_pkg::ST_DISP;
                end
            end
            scs_pkg::ST_DISP: begin
                cmd.iter_init = 1'b1;
                case (st.act)
                    scs_pkg::ACT_ADD:    state_next = scs_pkg::ST_MUL;
                    scs_pkg::ACT_MEAN,
                    scs_pkg::ACT_MEDIAN: state_next = scs_pkg::ST_ROW;
                    scs_pkg::ACT_CLEAR: begin
                        cmd.seed_load = 1'b1;
                        state_next    = scs_pkg::ST_CLR;
                    end
                    default:             state_next = scs_pkg::ST_FIN;
                endcase
            end
            scs_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = scs_pkg::ST_ROW;
            end
            scs_pkg::ST_ROW: begin
                if (st.iter_done) begin
                    if (st.act == scs_pkg::ACT_MEAN)        state_next = scs_pkg::ST_MEAN;
                    else if (st.act == scs_pkg::ACT_MEDIAN) state_next = scs_pkg::ST_SORT;
                    else                                    state_next = scs_pkg::ST_FIN;
                end else if (st.act == scs_pkg::ACT_ADD && st.row_ge) begin
                    cmd.row_wrap = 1'b1;
                    state_next   = scs_pkg::ST_FIN;
                end else begin
                    cmd.hash_init = 1'b1;
                    state_next    = scs_pkg::ST_HASH;
                end
            end
            scs_pkg::ST_HASH: begin
                if (st.hash_done) begin
                    cmd.div_mod = 1'b1;
                    state_next  = scs_pkg::ST_MOD;
                end else begin
                    cmd.hash_step = 1'b1;
                end
            end
            scs_pkg::ST_MOD: begin
                if (st.div_done) begin
                    cmd.mem_rd = 1'b1;
                    state_next = scs_pkg::ST_RD;
                end
            end
            scs_pkg::ST_RD: begin
                cmd.acc    = 1'b1;
                state_next = (st.act == scs_pkg::ACT_ADD) ? scs_pkg::ST_SKIP : scs_pkg::ST_ROW;
            end
            scs_pkg::ST_SKIP: begin
                cmd.skip_step = 1'b1;
                if (st.skip_end) state_next = scs_pkg::ST_ROW;
            end
            scs_pkg::ST_MEAN: begin
                cmd.div_mean = 1'b1;
                state_next   = scs_pkg::ST_MEANW;
            end
            scs_pkg::ST_MEANW: begin
                if (st.div_done) state_next = scs_pkg::ST_FIN;
            end
            scs_pkg::ST_SORT: begin
                if (st.sort_done) state_next = scs_pkg::ST_SHIFT;
                else              cmd.sort_step = 1'b1;
            end
            scs_pkg::ST_SHIFT: begin
                if (st.shift_done) state_next = scs_pkg::ST_FIN;
                else               cmd.shift_step = 1'b1;
            end
            scs_pkg::ST_CLR: begin
                cmd.sweep_step = 1'b1;
                if (st.sweep_last) state_next = scs_pkg::ST_FIN;
            end
            scs_pkg::ST_FIN: begin
                if (!st.out_full) begin
                    cmd.res_load = 1'b1;
                    state_next   = scs_pkg::ST_IDLE;
                end
            end
            default: state_next = scs_pkg::ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_ready && s_tvalid) |=> !in_ready)
        else $error("input taken again right after a beat");
    a_div_done_where_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        st.div_done |-> (state_reg == scs_pkg::ST_MOD || state_reg == scs_pkg::ST_MEANW))
        else $error("divider finished with nobody waiting");
    a_skip_only_on_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == scs_pkg::ST_SKIP) |-> (st.act == scs_pkg::ACT_ADD))
        else $error("row skip drawn outside an add");
`endif

endmodule

>>> hw/rtl/sampled_count_sketch.sv
// per item, for each visited row: hash over the key bytes, bit-serial modulo of the
//   64-bit hash, counter read and update, then on an add the lfsr skip draws; a query
//   then divides the row sum by the rows used for the mean, or sorts and shifts the lanes
//   for the median pick; a clear sweeps every cell of the store to zero
// throughput: one item in flight, next beat taken in the cycle after its result is loaded
// reset (aresetn low, synchronous) then sweeps all MAX_ROWS*MAX_COLUMNS cells of the store to zero
module sampled_count_sketch #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_SKIP    = 255
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // fields from bit 0: key_bytes[63:0], key_len[67:64], increment[99:68], zero pad
    input  logic [scs_pkg::S_DATA_W-1:0]   s_tdata,
    // fields from bit 0: action[1:0]
    input  logic [scs_pkg::ACT_W-1:0]      s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // fields from bit 0: estimate[55:0]
    output logic [scs_pkg::EST_W-1:0]      m_tdata,
    // fields from bit 0: saturated[0]
    output logic                           m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0] cfg_data
);
    scs_pkg::cmd_t    cmd;
    scs_pkg::status_t st;

    // sequencer: states for the phases of an item (hash, modulo, read and update, skip)
    scs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .st       (st),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    // counter store, hash, divider, lfsr, median lanes and output register
    scs_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_SKIP    (MAX_SKIP)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

>>> tb/sv/sampled_count_sketch_tb.sv
module sampled_count_sketch_tb;
    import scs_pkg::*;

    localparam int N_ROWS    = 8;
    localparam int N_COLS    = 1024;
    localparam int SKIP_CAP  = 255;
    localparam int STALL_CAP = 40000;   // cycles with no beat anywhere before giving up
    localparam int HOLD_LEN  = 400;     // long receiver hold-off

    typedef struct {
        logic [EST_W-1:0] estimate;
        logic             saturated;
    } sketch_out_t;

    // sketch mirror: counter store, row pointer, lfsr and registers
    class sketch_scoreboard;
        logic [EST_W-1:0]  cells[N_ROWS*N_COLS];
        logic [8:0]        row_ptr;
        logic [31:0]       lfsr;
        logic [3:0]        rows_reg;
        logic [10:0]       cols_reg;
        logic [16:0]       prob_reg;
        logic [24:0]       gain_reg;
        logic [31:0]       seed_reg;
        sketch_out_t       pending_q[$];
        int                errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            row_ptr  = '0;
            lfsr     = 32'd1;
            rows_reg = 4'd8;
            cols_reg = 11'd1024;
            prob_reg = 17'd65536;
            gain_reg = 25'd256;
            seed_reg = 32'd1;
            errors   = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] v);
            case (idx)
                CFG_ROWS: rows_reg = v[3:0];
                CFG_COLS: cols_reg = v[10:0];
                CFG_PROB: prob_reg = v[16:0];
                CFG_GAIN: gain_reg = v[24:0];
                CFG_SEED: seed_reg = v;
                default: ;
            endcase
        endfunction

        function int active_rows();
            return rows_reg == 0 ? 1 : (rows_reg > N_ROWS ? N_ROWS : rows_reg);
        endfunction

        function int active_cols();
            return cols_reg == 0 ? 1 : (cols_reg > N_COLS ? N_COLS : cols_reg);
        endfunction

        // fnv-1a with per-row offset basis, then reduced to a column
        function int column_of(logic [63:0] k, logic [3:0] len, int r);
            logic [63:0] h;
            int          n;
            h = 64'hCBF29CE484222325 + 64'd31 * r;
            n = len > 8 ? 8 : len;
            for (int i = 0; i < n; i++) begin
                h = h ^ {56'd0, k[8*i +: 8]};
                h = h * 64'd1099511628211;
            end
            return int'(h % active_cols());
        endfunction

        function int draw_skip();
            int          p;
            int          k;
            logic [31:0] s;
            p = prob_reg == 0 ? 1 : (prob_reg > 65536 ? 65536 : prob_reg);
            k = 1;
            forever begin
                s    = lfsr;
                lfsr = (s >> 1) ^ (s[0] ? LFSR_TAPS : 32'd0);
                if (int'(lfsr[15:0]) < p) break;
                if (k >= SKIP_CAP) break;
                k++;
            end
            return k;
        endfunction

        // works out the result of one accepted input beat
        function void note_input(action_t act, logic [63:0] k, logic [3:0] len,
                                 logic [31:0] inc);
            sketch_out_t res;
            int          rows;
            logic [63:0] amt;
            logic [63:0] gain;
            logic [63:0] sum;
            logic [63:0] vals[N_ROWS];
            logic [63:0] x;
            int          r;
            int          j;
            int          idx;
            rows = active_rows();
            res.estimate  = '0;
            res.saturated = 1'b0;
            case (act)
                ACT_ADD: begin
                    gain = gain_reg == 0 ? 64'd1 : (gain_reg > GAIN_MAX ? 64'd16777216
                                                                         : 64'(gain_reg));
                    amt = 64'(inc) * gain;
                    if (amt > 64'(CNT_MAX)) begin
                        amt = 64'(CNT_MAX);
                        res.saturated = 1'b1;
                    end
                    for (int i = 0; i < rows; i++) begin
                        r = row_ptr;
                        if (r >= rows) begin
                            row_ptr = 9'(r - rows);
                            break;
                        end
                        idx = r * N_COLS + column_of(k, len, r);
                        sum = 64'(cells[idx]) + amt;
                        if (sum > 64'(CNT_MAX)) begin
                            sum = 64'(CNT_MAX);
                            res.saturated = 1'b1;
                        end
                        cells[idx] = sum[EST_W-1:0];
                        if (r == rows - 1) r = 0;
                        row_ptr = 9'(r + draw_skip());
                    end
                end
                ACT_MEAN: begin
                    sum = '0;
                    for (int i = 0; i < rows; i++)
                        sum += cells[i*N_COLS + column_of(k, len, i)];
                    res.estimate = EST_W'(sum / rows);
                end
                ACT_MEDIAN: begin
                    for (int i = 0; i < rows; i++) begin
                        x = cells[i*N_COLS + column_of(k, len, i)];
                        j = i;
                        while (j > 0 && vals[j-1] > x) begin
                            vals[j] = vals[j-1];
                            j--;
                        end
                        vals[j] = x;
                    end
                    if (rows % 2 == 0)
                        res.estimate = EST_W'((vals[rows/2] + vals[rows/2-1]) / 2);
                    else
                        res.estimate = EST_W'(vals[rows/2]);
                end
                default: begin
                    foreach (cells[i]) cells[i] = '0;
                    lfsr = seed_reg != 0 ? seed_reg : 32'd1;
                end
            endcase
            pending_q.push_back(res);
        endfunction

        function void check_result(logic [EST_W-1:0] est, logic sat);
            sketch_out_t want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result beat estimate=%h saturated=%b",
                         $time, est, sat);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (est !== want.estimate) begin
                $display("%0t: estimate mismatch expected %h actual %h",
                         $time, want.estimate, est);
                errors++;
            end
            if (sat !== want.saturated) begin
                $display("%0t: saturated mismatch expected %b actual %b",
                         $time, want.saturated, sat);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [ACT_W-1:0]      s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [EST_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sketch_scoreboard sb;
    bit               idle_on;      // random gaps on both sides when set
    bit               hold_req;     // asks the receiver for one long hold-off
    int               quiet_cycles;
    logic [63:0]      key_pool[16];
    logic [3:0]       len_pool[16];

    sampled_count_sketch dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // monitors: inputs feed the mirror, results are checked in order
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_input(action_t'(s_tuser), s_tdata[63:0], s_tdata[67:64],
                          s_tdata[99:68]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_CAP) begin
            $display("%0t: no progress, timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls per beat, plus one long hold-off on request
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                hold_req = 1'b0;
            end
            n = idle_on ? $urandom_range(0, 8) : 0;
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_beat(action_t act, logic [63:0] k, logic [3:0] len,
                             logic [31:0] inc);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'd0, inc, len, k};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // new register setting for a phase; extremes show up often
    task automatic program_phase(int ph);
        logic [31:0] v;
        drain();
        case ($urandom_range(0, 3))
            0: v = 0;
            1: v = 32'd8;
            2: v = $urandom_range(9, 15);
            default: v = $urandom_range(1, 8);
        endcase
        write_reg(CFG_ROWS, {$urandom_range(0, 1) ? 28'h0 : 28'(ph), v[3:0]});
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = 1;
            2: v = $urandom_range(1025, 2047);
            3: v = 1024;
            default: v = $urandom_range(2, 64);
        endcase
        write_reg(CFG_COLS, v);
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 65536;
            2: v = $urandom_range(65537, 131071);
            3: v = $urandom_range(1, 3000);
            default: v = $urandom_range(8000, 65535);
        endcase
        write_reg(CFG_PROB, v);
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = 16777216;
            2: v = $urandom_range(16777217, 33554431);
            3: v = $urandom();
            default: v = $urandom_range(1, 1024);
        endcase
        write_reg(CFG_GAIN, v);
        write_reg(CFG_SEED, $urandom_range(0, 7) == 0 ? 32'd0 : $urandom());
        write_reg(cfg_idx_t'($urandom_range(5, 7)), $urandom());
        foreach (key_pool[i]) begin
            key_pool[i] = {$urandom(), $urandom()};
            len_pool[i] = $urandom_range(0, 15);
        end
    endtask

    task automatic random_beat();
        int          pick;
        int          slot;
        logic [63:0] k;
        logic [3:0]  len;
        logic [31:0] inc;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, 15);
        k    = key_pool[slot];
        len  = len_pool[slot];
        if ($urandom_range(0, 9) == 0) begin
            k   = {$urandom(), $urandom()};
            len = $urandom_range(0, 15);
        end
        inc = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 300);
        if (pick < 60)
            send_beat(ACT_ADD, k, len, inc);
        else if (pick < 79)
            send_beat(ACT_MEAN, k, len, inc);
        else if (pick < 98)
            send_beat(ACT_MEDIAN, k, len, inc);
        else
            send_beat(ACT_CLEAR, k, len, inc);
    endtask

    initial begin
        sb        = new();
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: key and length extremes under reset defaults
        send_beat(ACT_ADD, 64'd0, 4'd0, 32'd0);
        send_beat(ACT_ADD, '1, 4'd8, 32'hFFFF_FFFF);
        send_beat(ACT_ADD, 64'h0123_4567_89AB_CDEF, 4'd15, 32'd5);
        send_beat(ACT_ADD, 64'h0123_4567_89AB_CDEF, 4'd8, 32'd7);
        send_beat(ACT_MEAN, '1, 4'd8, 32'd0);
        send_beat(ACT_MEDIAN, '1, 4'd8, 32'd0);
        send_beat(ACT_MEAN, 64'h0123_4567_89AB_CDEF, 4'd8, 32'd0);
        send_beat(ACT_MEDIAN, 64'd0, 4'd0, '1);
        stop_sending();
        drain();
        // directed: saturation with the largest gain, then an out-of-range gain
        write_reg(CFG_GAIN, 32'd16777216);
        write_reg(CFG_ROWS, 32'd5);
        send_beat(ACT_ADD, 64'hAA, 4'd1, 32'hFFFF_FFFF);
        send_beat(ACT_ADD, 64'hAA, 4'd1, 32'd1);
        send_beat(ACT_ADD, 64'hAA, 4'd1, 32'h10);
        send_beat(ACT_MEDIAN, 64'hAA, 4'd1, 32'd0);
        send_beat(ACT_MEAN, 64'hAA, 4'd1, 32'd0);
        stop_sending();
        drain();
        write_reg(CFG_GAIN, 32'h1FF_FFFF);
        write_reg(CFG_SEED, 32'd0);
        write_reg(CFG_ROWS, 32'd0);
        write_reg(cfg_idx_t'(5), 32'hFFFF_FFFF);
        send_beat(ACT_ADD, 64'h55, 4'd1, 32'd300);
        send_beat(ACT_CLEAR, 64'd0, 4'd0, 32'd0);
        send_beat(ACT_MEAN, 64'h55, 4'd1, 32'd0);
        send_beat(ACT_ADD, 64'h55, 4'd9, 32'd3);
        send_beat(ACT_MEDIAN, 64'h55, 4'd9, 32'd0);
        stop_sending();

        // random phases; one without idling, one with the long receiver hold-off,
        // one with a mid-phase pause until every result is back
        for (int ph = 0; ph < 10; ph++) begin
            program_phase(ph);
            idle_on = (ph != 2);
            if (ph == 4) hold_req = 1'b1;
            for (int i = 0; i < 123; i++) begin
                if (ph == 6 && i == 60) begin
                    stop_sending();
                    while (sb.outstanding() != 0) @(posedge aclk);
                end
                random_beat();
            end
            stop_sending();
        end

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/scs_pkg.sv
hw/rtl/scs_div.sv
hw/rtl/scs_dp.sv
hw/rtl/scs_ctrl.sv
hw/rtl/sampled_count_sketch.sv
tb/sv/sampled_count_sketch_tb.sv
